// ===== design/stepper_step_pulse_generator_macros.svh =====
// Assertion helpers for the step pulse generator.
`ifndef STEPPER_STEP_PULSE_GENERATOR_MACROS_SVH
`define STEPPER_STEP_PULSE_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spg: implication violated");

// Condition must never be seen.
`define SPG_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("spg: forbidden condition seen");

`endif

// ===== design/spg_pkg.sv =====
`default_nettype none

package spg_pkg;

   localparam int SPEED_W   = 24;
   localparam int ANGLE_W   = 32;
   localparam int MSTEP_W   = 9;
   localparam int DEN_W     = SPEED_W + MSTEP_W;
   localparam int APROD_W   = ANGLE_W + MSTEP_W;
   localparam int NUM_W     = 35;
   localparam int TARGET_W  = 32;

   // angle target: angle * microstep * 5 / 2304, with 2304 = 9 * 256
   localparam int FIVE_W     = APROD_W + 3;
   localparam int PRESHIFT   = 8;
   localparam int LO_W       = 18;
   localparam int HI_W       = FIVE_W - PRESHIFT - LO_W;
   localparam int DIV9_W     = 22;
   localparam int DIV9_SHIFT = 26;
   localparam int PROD9_W    = DIV9_W + DIV9_SHIFT;

   localparam logic [NUM_W-1:0]   SPEED_NUM       = NUM_W'(64'd29491200000);
   localparam logic [PROD9_W-1:0] DIV9_MUL        = PROD9_W'(7456541);
   localparam logic [MSTEP_W-1:0] MICROSTEP_RESET = MSTEP_W'(64);

   typedef enum logic [1:0] {
      FUNC_TICK      = 2'd0,
      FUNC_RUN_CONT  = 2'd1,
      FUNC_RUN_ANGLE = 2'd2,
      FUNC_STOP      = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TGT_HI,
      ST_TGT_LO,
      ST_PER,
      ST_PER_WAIT,
      ST_APPLY
   } ctrl_state_type;

   typedef struct packed {
      logic tick;
      logic halt;
      logic hold_rsp;
      logic capture;
      logic div_start;
      logic tgt_hi;
      logic tgt_save;
      logic apply;
      logic apply_angle;
   } spg_cmd_type;

   typedef struct packed {
      logic speed_zero;
      logic angle_zero;
      logic den_zero;
      logic div_busy;
      logic div_done;
   } spg_stat_type;

endpackage

`default_nettype wire

// ===== design/spg_div.sv =====
`default_nettype none

module spg_div
   import spg_pkg::*;
#(
   parameter int DVD_W = 44,
   parameter int DVS_W = 33
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             ge;

   // one quotient bit a cycle, restoring
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/spg_ctrl.sv =====
`default_nettype none

module spg_ctrl
   import spg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic [1:0]   req_func,
   input  wire logic         rsp_ready,
   input  wire spg_stat_type stat,
   output spg_cmd_type       cmd,
   output logic              req_ready,
   output logic              rsp_valid
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           angle_mode_ff, angle_mode_in;
   logic           slot_free;
   logic           accept;
   func_type       func;

   assign func      = func_type'(req_func);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      angle_mode_in = angle_mode_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func)
                  FUNC_TICK: cmd.tick = 1'b1;
                  FUNC_STOP: cmd.halt = 1'b1;
                  FUNC_RUN_CONT: begin
                     if (stat.speed_zero) begin
                        cmd.halt = 1'b1;
                     end else begin
                        cmd.capture   = 1'b1;
                        angle_mode_in = 1'b0;
                        state_in      = ST_PER;
                     end
                  end
                  FUNC_RUN_ANGLE: begin
                     if (stat.speed_zero || stat.angle_zero) begin
                        cmd.hold_rsp = 1'b1;
                     end else begin
                        cmd.capture   = 1'b1;
                        angle_mode_in = 1'b1;
                        state_in      = ST_TGT_HI;
                     end
                  end
                  default: cmd.hold_rsp = 1'b1;
               endcase
            end
         end
         ST_TGT_HI: begin
            cmd.tgt_hi = 1'b1;
            state_in   = ST_TGT_LO;
         end
         ST_TGT_LO: begin
            cmd.tgt_save = 1'b1;
            state_in     = ST_PER;
         end
         ST_PER: begin
            // zero denominator takes the longest period, no division
            if (stat.den_zero) begin
               state_in = ST_APPLY;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_PER_WAIT;
            end
         end
         ST_PER_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (slot_free) begin
               cmd.apply       = 1'b1;
               cmd.apply_angle = angle_mode_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.tick || cmd.halt || cmd.hold_rsp || cmd.apply) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      angle_mode_ff <= angle_mode_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/spg_dp.sv =====
`default_nettype none

module spg_dp
   import spg_pkg::*;
#(
   parameter int PERIOD_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [MSTEP_W-1:0] csr_wr_data,
   input  wire logic [SPEED_W-1:0] req_speed,
   input  wire logic               req_direction,
   input  wire logic [ANGLE_W-1:0] req_angle,
   input  wire spg_cmd_type        cmd,
   output spg_stat_type            stat,
   output logic                    rsp_step_level,
   output logic                    rsp_dir_level,
   output logic                    rsp_enable_level,
   output logic                    rsp_running,
   output logic                    rsp_done_res
);

   localparam int PB = PERIOD_BITS;
   localparam logic [NUM_W-1:0] MAX_P = {{(NUM_W-1){1'b0}}, 1'b1} << PB;
   localparam int REM9_W = DIV9_W - LO_W;

   // divide by nine through a reciprocal, exact below 2^DIV9_W
   function automatic logic [DIV9_W-1:0] div9(input logic [DIV9_W-1:0] x);
      logic [PROD9_W-1:0] prod;
      prod = PROD9_W'(x) * DIV9_MUL;
      return prod[PROD9_W-1:DIV9_SHIFT];
   endfunction

   logic [MSTEP_W-1:0]  microstep_ff, microstep_in;
   logic [PB-1:0]       tick_ff, tick_in;
   logic [PB-1:0]       top_ff, top_in;
   logic [PB-1:0]       high_ff, high_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [TARGET_W-1:0] pulse_ff, pulse_in;
   logic                active_ff, active_in;
   logic                counting_ff, counting_in;
   logic                dir_ff, dir_in;
   logic                enable_ff, enable_in;
   logic [DEN_W-1:0]    den_ff;
   logic [APROD_W-1:0]  aprod_ff;
   logic                dir_cap_ff;
   logic [HI_W-1:0]     tgt_hi_ff;
   logic [LO_W-1:0]     tgt_lo_ff;
   logic [HI_W-1:0]     tgt_hq_ff;
   logic [TARGET_W-1:0] tgt_q_ff;
   logic                step_ff, step_in;
   logic                done_ff, done_in;

   logic [DEN_W-1:0]    den_prod;
   logic [APROD_W-1:0]  aprod_prod;
   logic [FIVE_W-1:0]   five_p;
   logic [DIV9_W-1:0]   hi_quo;
   logic [HI_W+2:0]     hi_nine;
   logic [HI_W+2:0]     hi_rem;
   logic [DIV9_W-1:0]   lo_num;
   logic [DIV9_W-1:0]   lo_quo;
   logic [NUM_W-1:0]    quotient;
   logic                div_busy;
   logic                div_done;
   logic [PB:0]         period;
   logic [TARGET_W-1:0] pulse_inc;

   assign den_prod   = DEN_W'(req_speed) * DEN_W'(microstep_ff);
   assign aprod_prod = APROD_W'(req_angle) * APROD_W'(microstep_ff);

   // angle target: drop the factor 256 first, then divide by nine in two
   // digits, the high one in state ST_TGT_HI and the low one in ST_TGT_LO
   assign five_p  = {1'b0, aprod_ff, 2'b00} + {3'b000, aprod_ff};
   assign hi_quo  = div9(DIV9_W'(five_p[FIVE_W-1 -: HI_W]));
   assign hi_nine = {tgt_hq_ff, 3'b000} + {3'b000, tgt_hq_ff};
   assign hi_rem  = {3'b000, tgt_hi_ff} - hi_nine;
   assign lo_num  = {hi_rem[REM9_W-1:0], tgt_lo_ff};
   assign lo_quo  = div9(lo_num);

   // period: constant / (speed * microstep)
   spg_div #(
      .DVD_W (NUM_W),
      .DVS_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (SPEED_NUM),
      .divisor  (den_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   assign stat.speed_zero = (req_speed == '0);
   assign stat.angle_zero = (req_angle == '0);
   assign stat.den_zero   = (den_ff == '0);
   assign stat.div_busy   = div_busy;
   assign stat.div_done   = div_done;

   // clamp the period to 2 .. 2^PB
   always_comb begin
      if (stat.den_zero || (quotient > MAX_P)) begin
         period = MAX_P[PB:0];
      end else if (quotient < NUM_W'(2)) begin
         period = (PB+1)'(2);
      end else begin
         period = quotient[PB:0];
      end
   end

   assign pulse_inc = (pulse_ff == '1) ? pulse_ff : pulse_ff + TARGET_W'(1);

   always_comb begin
      microstep_in = csr_wr_en ? csr_wr_data : microstep_ff;
      tick_in      = tick_ff;
      top_in       = top_ff;
      high_in      = high_ff;
      target_in    = target_ff;
      pulse_in     = pulse_ff;
      active_in    = active_ff;
      counting_in  = counting_ff;
      dir_in       = dir_ff;
      enable_in    = enable_ff;
      step_in      = 1'b0;
      done_in      = 1'b0;
      if (cmd.tick) begin
         if (active_ff) begin
            step_in = (tick_ff < high_ff);
            if (tick_ff >= top_ff) begin
               tick_in = '0;
               if (counting_ff && (target_ff != '0)) begin
                  pulse_in = pulse_inc;
                  if (pulse_inc >= target_ff) begin
                     active_in   = 1'b0;
                     counting_in = 1'b0;
                     done_in     = 1'b1;
                  end
               end
            end else begin
               tick_in = tick_ff + PB'(1);
            end
         end
      end else if (cmd.halt) begin
         active_in   = 1'b0;
         counting_in = 1'b0;
      end else if (cmd.apply) begin
         enable_in = 1'b1;
         dir_in    = dir_cap_ff;
         tick_in   = '0;
         top_in    = PB'(period - (PB+1)'(1));
         high_in   = period[PB:1];
         active_in = 1'b1;
         if (cmd.apply_angle) begin
            target_in   = tgt_q_ff;
            pulse_in    = '0;
            counting_in = 1'b1;
         end else begin
            target_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         microstep_ff <= MICROSTEP_RESET;
         tick_ff      <= '0;
         top_ff       <= '0;
         high_ff      <= '0;
         target_ff    <= '0;
         pulse_ff     <= '0;
         active_ff    <= 1'b0;
         counting_ff  <= 1'b0;
         dir_ff       <= 1'b0;
         enable_ff    <= 1'b0;
      end else begin
         microstep_ff <= microstep_in;
         tick_ff      <= tick_in;
         top_ff       <= top_in;
         high_ff      <= high_in;
         target_ff    <= target_in;
         pulse_ff     <= pulse_in;
         active_ff    <= active_in;
         counting_ff  <= counting_in;
         dir_ff       <= dir_in;
         enable_ff    <= enable_in;
      end
      if (cmd.capture) begin
         den_ff     <= den_prod;
         aprod_ff   <= aprod_prod;
         dir_cap_ff <= req_direction;
      end
      if (cmd.tgt_hi) begin
         tgt_hi_ff <= five_p[FIVE_W-1 -: HI_W];
         tgt_lo_ff <= five_p[PRESHIFT +: LO_W];
         tgt_hq_ff <= hi_quo[HI_W-1:0];
      end
      // saturate a target that does not fit in 32 bits
      if (cmd.tgt_save) begin
         tgt_q_ff <= (tgt_hq_ff[HI_W-1:TARGET_W-LO_W] != '0) ? '1
                   : {tgt_hq_ff[TARGET_W-LO_W-1:0], lo_quo[LO_W-1:0]};
      end
      if (cmd.tick || cmd.halt || cmd.hold_rsp || cmd.apply) begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // pin levels only move when a result is loaded, so they read straight out
   assign rsp_step_level   = step_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_dir_level    = dir_ff;
   assign rsp_enable_level = enable_ff;
   assign rsp_running      = active_ff;

endmodule

`default_nettype wire

// ===== design/stepper_step_pulse_generator.sv =====
// Step/direction pulse generator. Each item is a timer tick or a command and yields one
// result. Ticks, stop commands and ignored commands are handled straight from idle and can be
// accepted every cycle while results are taken. A run command goes through the
// one-bit-per-cycle period divider (35 steps), and the next item is taken only after the
// run has put out its result. A run by angle first scales the angle to a pulse target in
// the states ST_TGT_HI and ST_TGT_LO. When speed * microstep is zero the division is skipped.
// A result that waits for the receiver holds back the next item. The step period is
// 29491200000 / (speed * microstep) timer ticks, clamped to 2 .. 2^PERIOD_BITS; the step
// pin is high for the first half of each period.
`default_nettype none

`include "stepper_step_pulse_generator_macros.svh"

module stepper_step_pulse_generator
   import spg_pkg::*;
#(
   parameter int PERIOD_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [MSTEP_W-1:0] csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_func,
   input  wire logic [SPEED_W-1:0] req_speed,
   input  wire logic               req_direction,
   input  wire logic [ANGLE_W-1:0] req_angle,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_step_level,
   output logic                    rsp_dir_level,
   output logic                    rsp_enable_level,
   output logic                    rsp_running,
   output logic                    rsp_done_res
);

   spg_cmd_type  cmd;
   spg_stat_type stat;

   spg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid)
   );

   spg_dp #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_speed        (req_speed),
      .req_direction    (req_direction),
      .req_angle        (req_angle),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_step_level   (rsp_step_level),
      .rsp_dir_level    (rsp_dir_level),
      .rsp_enable_level (rsp_enable_level),
      .rsp_running      (rsp_running),
      .rsp_done_res     (rsp_done_res)
   );

   `SPG_ASSERT_IMPLIES(a_done_stops, clock, reset, rsp_valid && rsp_done_res, !rsp_running)
   `SPG_ASSERT_IMPLIES(a_div_free, clock, reset, cmd.div_start, !stat.div_busy)
   `SPG_ASSERT_NEVER(a_enable_sticky, clock, reset, $fell(rsp_enable_level))
   `SPG_ASSERT_IMPLIES(a_stop_by_item, clock, reset, $fell(rsp_running), $past(req_valid && req_ready))

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
   import spg_pkg::*;

   localparam int PERIOD_BITS = 16;
   localparam longint unsigned STEP_NUMERATOR = 64'd29491200000;
   localparam longint unsigned FULL_PERIOD    = 64'd1 << PERIOD_BITS;
   localparam longint unsigned SHORTEST_PERIOD = 64'd2;
   localparam longint unsigned GOAL_MUL       = 64'd5;
   localparam longint unsigned GOAL_DIV       = 64'd2304;
   localparam int PHASE_ITEMS = 50;

   typedef struct {
      func_type           func;
      logic [SPEED_W-1:0] speed;
      logic               direction;
      logic [ANGLE_W-1:0] angle;
   } step_cmd_t;

   typedef struct {
      logic step_level;
      logic dir_level;
      logic enable_level;
      logic running;
      logic done_res;
   } pin_state_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [MSTEP_W-1:0] csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = '0;
   logic [SPEED_W-1:0] req_speed = '0;
   logic               req_direction = 1'b0;
   logic [ANGLE_W-1:0] req_angle = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_step_level;
   logic               rsp_dir_level;
   logic               rsp_enable_level;
   logic               rsp_running;
   logic               rsp_done_res;

   stepper_step_pulse_generator #(
      .PERIOD_BITS(PERIOD_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_speed        (req_speed),
      .req_direction    (req_direction),
      .req_angle        (req_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_step_level   (rsp_step_level),
      .rsp_dir_level    (rsp_dir_level),
      .rsp_enable_level (rsp_enable_level),
      .rsp_running      (rsp_running),
      .rsp_done_res     (rsp_done_res)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   step_cmd_t  items_to_send[$];
   pin_state_t pin_results_due[$];
   int         items_queued = 0;
   int         err_count = 0;
   int         send_gap_pct = 0;
   int         recv_stall_pct = 0;
   logic       req_taken = 1'b0;

   // motor model state
   logic [MSTEP_W-1:0]  microstep_now = MICROSTEP_RESET;
   logic [15:0]         ticks_in_period = '0;
   logic [15:0]         top_tick = '0;
   logic [15:0]         half_ticks = '0;
   logic [TARGET_W-1:0] pulse_goal = '0;
   logic [TARGET_W-1:0] pulses_sent = '0;
   logic                motor_on = 1'b0;
   logic                counting_on = 1'b0;
   logic                dir_pin = 1'b0;
   logic                enable_pin = 1'b0;

   task automatic note_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      err_count++;
   endtask

   function automatic longint unsigned step_period(input logic [SPEED_W-1:0] spd,
                                                   input logic [MSTEP_W-1:0] ms);
      longint unsigned den;
      longint unsigned p;
      den = 64'(spd) * 64'(ms);
      p = (den == 0) ? FULL_PERIOD : STEP_NUMERATOR / den;
      if (p < SHORTEST_PERIOD) p = SHORTEST_PERIOD;
      if (p > FULL_PERIOD) p = FULL_PERIOD;
      return p;
   endfunction

   function automatic logic [TARGET_W-1:0] angle_goal(input logic [ANGLE_W-1:0] ang,
                                                      input logic [MSTEP_W-1:0] ms);
      longint unsigned t;
      t = 64'(ang) * 64'(ms) * GOAL_MUL / GOAL_DIV;
      return (t > 64'hFFFF_FFFF) ? '1 : 32'(t);
   endfunction

   task automatic load_period(input logic [SPEED_W-1:0] spd);
      longint unsigned p;
      p = step_period(spd, microstep_now);
      top_tick = 16'(p - 1);
      half_ticks = 16'(p / 2);
      ticks_in_period = '0;
   endtask

   task automatic advance_pins(input step_cmd_t c, output pin_state_t r);
      r = '{default: 1'b0};
      case (c.func)
         FUNC_TICK: begin
            if (motor_on) begin
               r.step_level = (ticks_in_period < half_ticks);
               if (ticks_in_period >= top_tick) begin
                  ticks_in_period = '0;
                  if (counting_on && pulse_goal != 0) begin
                     if (pulses_sent != '1) pulses_sent = pulses_sent + 1;
                     if (pulses_sent >= pulse_goal) begin
                        motor_on = 1'b0;
                        counting_on = 1'b0;
                        r.done_res = 1'b1;
                     end
                  end
               end else begin
                  ticks_in_period = ticks_in_period + 1;
               end
            end
         end
         FUNC_RUN_CONT: begin
            if (c.speed == 0) begin
               motor_on = 1'b0;
               counting_on = 1'b0;
            end else begin
               enable_pin = 1'b1;
               dir_pin = c.direction;
               load_period(c.speed);
               pulse_goal = '0;
               motor_on = 1'b1;
            end
         end
         FUNC_RUN_ANGLE: begin
            if (c.speed != 0 && c.angle != 0) begin
               enable_pin = 1'b1;
               dir_pin = c.direction;
               pulse_goal = angle_goal(c.angle, microstep_now);
               pulses_sent = '0;
               load_period(c.speed);
               motor_on = 1'b1;
               counting_on = 1'b1;
            end
         end
         FUNC_STOP: begin
            motor_on = 1'b0;
            counting_on = 1'b0;
         end
      endcase
      r.dir_level = dir_pin;
      r.enable_level = enable_pin;
      r.running = motor_on;
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // hold the item until it has been taken
         if (!req_valid || req_taken) begin
            if (req_valid) items_to_send.delete(0);
            if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_func <= items_to_send[0].func;
               req_speed <= items_to_send[0].speed;
               req_direction <= items_to_send[0].direction;
               req_angle <= items_to_send[0].angle;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: sample on the rising edge
   always @(posedge clock) begin
      step_cmd_t  c;
      pin_state_t want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            c.func = func_type'(req_func);
            c.speed = req_speed;
            c.direction = req_direction;
            c.angle = req_angle;
            advance_pins(c, want);
            pin_results_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pin_results_due.size() == 0) begin
               note_mismatch("result with no item waiting");
            end else begin
               want = pin_results_due.pop_front();
               if (rsp_step_level !== want.step_level)
                  note_mismatch($sformatf("step_level got %b want %b",
                                          rsp_step_level, want.step_level));
               if (rsp_dir_level !== want.dir_level)
                  note_mismatch($sformatf("dir_level got %b want %b",
                                          rsp_dir_level, want.dir_level));
               if (rsp_enable_level !== want.enable_level)
                  note_mismatch($sformatf("enable_level got %b want %b",
                                          rsp_enable_level, want.enable_level));
               if (rsp_running !== want.running)
                  note_mismatch($sformatf("running got %b want %b",
                                          rsp_running, want.running));
               if (rsp_done_res !== want.done_res)
                  note_mismatch($sformatf("done_res got %b want %b",
                                          rsp_done_res, want.done_res));
            end
         end
      end
   end

   task automatic send(input func_type f, input logic [SPEED_W-1:0] spd,
                       input logic dir, input logic [ANGLE_W-1:0] ang);
      step_cmd_t c;
      c.func = f;
      c.speed = spd;
      c.direction = dir;
      c.angle = ang;
      items_to_send.push_back(c);
      items_queued++;
   endtask

   task automatic send_ticks(input int n);
      for (int i = 0; i < n; i++)
         send(FUNC_TICK, 24'($urandom()), 1'($urandom_range(0, 1)), $urandom());
   endtask

   task automatic settle();
      while (items_to_send.size() != 0 || req_valid || pin_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_microstep(input logic [MSTEP_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      microstep_now = value;
   endtask

   task automatic random_phase(input int n_items);
      int                 first;
      int                 pick;
      logic [SPEED_W-1:0] spd;
      logic [ANGLE_W-1:0] ang;
      longint unsigned    per;
      longint unsigned    goal;
      longint unsigned    span;
      first = items_queued;
      while (items_queued - first < n_items) begin
         pick = $urandom_range(0, 99);
         // favour fast speeds so that periods stay short
         spd = ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                           : 24'($urandom_range(8000000, 16777215));
         if (pick < 45) begin
            ang = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 40);
            send(FUNC_RUN_ANGLE, spd, 1'($urandom_range(0, 1)), ang);
            per = step_period(spd, microstep_now);
            goal = angle_goal(ang, microstep_now);
            span = per * goal;
            // run to the target and a little past it where that is short enough
            if (goal != 0 && span <= 120) span = span + $urandom_range(0, 4);
            else span = $urandom_range(1, 60);
            if ($urandom_range(0, 4) == 0) span = $urandom_range(0, int'(span));
            send_ticks(int'(span));
         end else if (pick < 70) begin
            send(FUNC_RUN_CONT, spd, 1'($urandom_range(0, 1)), $urandom());
            send_ticks($urandom_range(1, 80));
            if ($urandom_range(0, 2) == 0)
               send(FUNC_STOP, 24'($urandom()), 1'($urandom_range(0, 1)), $urandom());
         end else if (pick < 80) begin
            send(FUNC_STOP, 24'($urandom()), 1'($urandom_range(0, 1)), $urandom());
         end else if (pick < 85) begin
            send(FUNC_RUN_CONT, '0, 1'($urandom_range(0, 1)), $urandom());
         end else if (pick < 90) begin
            if ($urandom_range(0, 1) == 0)
               send(FUNC_RUN_ANGLE, '0, 1'($urandom_range(0, 1)), $urandom());
            else
               send(FUNC_RUN_ANGLE, spd, 1'($urandom_range(0, 1)), '0);
         end else begin
            repeat ($urandom_range(1, 5))
               send(func_type'($urandom_range(0, 3)), 24'($urandom()),
                    1'($urandom_range(0, 1)), $urandom());
         end
      end
   endtask

   initial begin
      logic [MSTEP_W-1:0] phase_ms[6];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // stopped motor, ignored commands, saturated period at the reset microstep
      send(FUNC_TICK, '0, 1'b0, '0);
      send(FUNC_STOP, '1, 1'b1, '1);
      send(FUNC_RUN_CONT, '0, 1'b1, '1);
      send(FUNC_RUN_ANGLE, '0, 1'b1, 32'd1000);
      send(FUNC_RUN_ANGLE, '1, 1'b1, '0);
      send(FUNC_RUN_CONT, 24'd1, 1'b1, '0);
      send_ticks(2);
      settle();

      // shortest periods, target of one, saturated target
      write_microstep('1);
      send(FUNC_RUN_CONT, '1, 1'b0, '1);
      send_ticks(4);
      send(FUNC_RUN_ANGLE, '1, 1'b1, 32'd1);
      send_ticks(4);
      send(FUNC_RUN_ANGLE, '1, 1'b0, '1);
      send_ticks(2);
      send(FUNC_RUN_CONT, '1, 1'b1, '0);
      send_ticks(1);
      send(FUNC_STOP, '0, 1'b0, '0);
      settle();

      // zero microstep: saturated period and an endless angle run
      write_microstep('0);
      send(FUNC_RUN_ANGLE, 24'd5, 1'b1, 32'd1000);
      send_ticks(2);
      send(FUNC_STOP, '0, 1'b0, '0);

      phase_ms[0] = MICROSTEP_RESET;
      phase_ms[1] = 9'd256;
      phase_ms[2] = 9'd1;
      phase_ms[3] = 9'($urandom_range(2, 510));
      phase_ms[4] = '1;
      phase_ms[5] = '0;
      for (int k = 0; k < 6; k++) begin
         settle();
         write_microstep(phase_ms[k]);
         send_gap_pct = (k % 4 == 1) ? 53 : (k % 4 == 3) ? 38 : 0;
         recv_stall_pct = (k % 4 == 2) ? 53 : (k % 4 == 3) ? 38 : 0;
         random_phase(PHASE_ITEMS);
      end

      settle();
      repeat (120) @(posedge clock);
      if (pin_results_due.size() != 0) note_mismatch("results still outstanding");
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
